// ----- rtl/tbc_pkg.sv -----
package tbc_pkg;

    localparam int PIXEL_W     = 8;
    localparam int GAIN_W      = 16;
    localparam int THR_W       = 8;
    localparam int COORD_W     = 12;
    localparam int COUNT_W     = 25;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // depth of the frame queue and of the result queue
    localparam int QUEUE_DEPTH = 2;

    // packed result word: centroid_x, centroid_y, foreground_pixels, centroid_valid
    localparam int RES_W = 2 * COORD_W + COUNT_W + 1;

    localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd22938;
    localparam logic [THR_W-1:0]   THR_RESET  = 8'd80;
    localparam logic [COUNT_W-1:0] TOTAL_CAP  = 25'h1FF_FFFF;

    // luma weights in Q14 and the rounding term
    localparam int GRAY_SUM_W = 22;
    localparam logic [GRAY_SUM_W-1:0] GRAY_B_COEF = 22'd1868;
    localparam logic [GRAY_SUM_W-1:0] GRAY_G_COEF = 22'd9617;
    localparam logic [GRAY_SUM_W-1:0] GRAY_R_COEF = 22'd4899;
    localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND  = 22'd8192;
    localparam int GRAY_SHIFT = 14;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CONTRAST_GAIN  = 1'b0,
        REG_DARK_THRESHOLD = 1'b1
    } cfg_reg_t;

endpackage

// ----- rtl/tbc_fifo.sv -----
module tbc_fifo
    import tbc_pkg::*;
#(
    parameter int WIDTH = RES_W,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         rd_en,
    output logic [WIDTH-1:0]             rd_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign rd_data = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/tbc_front.sv -----
module tbc_front
    import tbc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW      = $clog2(MAX_WIDTH),
    localparam int RW      = $clog2(MAX_HEIGHT),
    localparam int QW      = (CW > RW) ? CW : RW,
    localparam int SWM     = COUNT_W + QW,
    localparam int FRAME_W = COUNT_W + 2 * SWM
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    input  logic [PIXEL_W-1:0]    blue,
    input  logic [PIXEL_W-1:0]    green,
    input  logic [PIXEL_W-1:0]    red,
    input  logic                  end_of_line,
    input  logic                  end_of_frame,
    input  logic [GAIN_W-1:0]     contrast_gain,
    input  logic [THR_W-1:0]      dark_threshold,
    output logic                  pending_eof,
    output logic                  frame_push,
    output logic [FRAME_W-1:0]    frame_data
);

    localparam int SXW = COUNT_W + CW;
    localparam int SYW = COUNT_W + RW;

    logic [GRAY_SUM_W-1:0] gray_sum;

    logic                  s1_valid_reg;
    logic [PIXEL_W-1:0]    s1_gray_reg;
    logic                  s1_eol_reg;
    logic                  s1_eof_reg;

    logic [CW-1:0]         col_reg;
    logic [RW-1:0]         row_reg;
    logic [COUNT_W-1:0]    total_reg;
    logic [SXW-1:0]        sum_x_reg;
    logic [SYW-1:0]        sum_y_reg;
    logic [CW-1:0]         col_next;
    logic [RW-1:0]         row_next;
    logic [COUNT_W-1:0]    total_next;
    logic [SXW-1:0]        sum_x_next;
    logic [SYW-1:0]        sum_y_next;

    logic [PIXEL_W+GAIN_W-1:0] scaled_prod;
    logic                  foreground;
    logic [COUNT_W-1:0]    total_acc;
    logic [SXW-1:0]        sum_x_acc;
    logic [SYW-1:0]        sum_y_acc;

    // stage 1: luma
    assign gray_sum = GRAY_SUM_W'(blue) * GRAY_B_COEF
                    + GRAY_SUM_W'(green) * GRAY_G_COEF
                    + GRAY_SUM_W'(red) * GRAY_R_COEF
                    + GRAY_ROUND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_valid)
        begin
            s1_gray_reg <= gray_sum[GRAY_SHIFT +: PIXEL_W];
            s1_eol_reg  <= end_of_line;
            s1_eof_reg  <= end_of_frame;
        end
    end

    // stage 2: gain, threshold and accumulate
    assign scaled_prod = (PIXEL_W + GAIN_W)'(s1_gray_reg) * (PIXEL_W + GAIN_W)'(contrast_gain);
    assign foreground  = (scaled_prod[GAIN_W +: PIXEL_W] <= dark_threshold)
                       && (total_reg != TOTAL_CAP);

    assign total_acc = foreground ? total_reg + 1'b1 : total_reg;
    assign sum_x_acc = foreground ? sum_x_reg + SXW'(col_reg) : sum_x_reg;
    assign sum_y_acc = foreground ? sum_y_reg + SYW'(row_reg) : sum_y_reg;

    assign pending_eof = s1_valid_reg && s1_eof_reg;
    assign frame_push  = pending_eof;
    assign frame_data  = {total_acc, SWM'(sum_x_acc), SWM'(sum_y_acc)};

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        total_next = total_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        if (s1_valid_reg)
        begin
            if (s1_eof_reg)
            begin
                col_next   = '0;
                row_next   = '0;
                total_next = '0;
                sum_x_next = '0;
                sum_y_next = '0;
            end
            else
            begin
                total_next = total_acc;
                sum_x_next = sum_x_acc;
                sum_y_next = sum_y_acc;
                if (s1_eol_reg)
                begin
                    col_next = '0;
                    if (row_reg < RW'(MAX_HEIGHT - 1))
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else if (col_reg < CW'(MAX_WIDTH - 1))
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            total_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            total_reg <= total_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
    end

endmodule

// ----- rtl/tbc_back.sv -----
module tbc_back
    import tbc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW      = $clog2(MAX_WIDTH),
    localparam int RW      = $clog2(MAX_HEIGHT),
    localparam int QW      = (CW > RW) ? CW : RW,
    localparam int SWM     = COUNT_W + QW,
    localparam int FRAME_W = COUNT_W + 2 * SWM
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  frame_empty,
    input  logic [FRAME_W-1:0]    frame_data,
    output logic                  frame_pop,
    input  logic                  res_full,
    output logic                  res_push,
    output logic [RES_W-1:0]      res_data
);

    localparam int STEP_W = (QW > 1) ? $clog2(QW) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV_X = 4'b0010,
        ST_DIV_Y = 4'b0100,
        ST_PUSH  = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [SWM-1:0]      sum_y_reg;
    logic [SWM-1:0]      sum_y_next;
    logic [SWM-1:0]      rem_reg;
    logic [SWM-1:0]      rem_next;
    logic [SWM-1:0]      dsr_reg;
    logic [SWM-1:0]      dsr_next;
    logic [QW-1:0]       quo_reg;
    logic [QW-1:0]       quo_next;
    logic [QW-1:0]       qx_reg;
    logic [QW-1:0]       qx_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;

    logic [COUNT_W-1:0]  head_count;
    logic [SWM-1:0]      head_sum_x;
    logic [SWM-1:0]      head_sum_y;
    logic                fits;
    logic [QW-1:0]       quo_shift;
    logic                valid;

    assign head_count = frame_data[FRAME_W-1 -: COUNT_W];
    assign head_sum_x = frame_data[2*SWM-1 -: SWM];
    assign head_sum_y = frame_data[SWM-1:0];

    // one restoring step: quotient bit from the msb down
    assign fits      = (rem_reg >= dsr_reg);
    assign quo_shift = QW'({quo_reg, fits});

    assign valid    = (count_reg != '0);
    assign res_data = {valid ? COORD_W'(qx_reg) : COORD_W'(0),
                       valid ? COORD_W'(quo_reg) : COORD_W'(0),
                       count_reg, valid};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sum_y_next = sum_y_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        quo_next   = quo_reg;
        qx_next    = qx_reg;
        step_next  = step_reg;
        frame_pop  = 1'b0;
        res_push   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!frame_empty)
                begin
                    frame_pop  = 1'b1;
                    count_next = head_count;
                    sum_y_next = head_sum_y;
                    rem_next   = head_sum_x + SWM'(head_count >> 1);
                    dsr_next   = SWM'(head_count) << (QW - 1);
                    quo_next   = '0;
                    step_next  = STEP_W'(QW - 1);
                    state_next = (head_count == '0) ? ST_PUSH : ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                if (fits)
                begin
                    rem_next = rem_reg - dsr_reg;
                end
                quo_next  = quo_shift;
                dsr_next  = dsr_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    qx_next    = quo_shift;
                    quo_next   = '0;
                    rem_next   = sum_y_reg + SWM'(count_reg >> 1);
                    dsr_next   = SWM'(count_reg) << (QW - 1);
                    step_next  = STEP_W'(QW - 1);
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (fits)
                begin
                    rem_next = rem_reg - dsr_reg;
                end
                quo_next  = quo_shift;
                dsr_next  = dsr_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        sum_y_reg <= sum_y_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        quo_reg   <= quo_next;
        qx_reg    <= qx_next;
        step_reg  <= step_next;
    end

endmodule

// ----- rtl/threshold_blob_centroid.sv -----
// pixels: one per cycle while not full, two-stage front (luma, then gain/threshold/accumulate)
// frame result: readable after the front, frame queue, QW-bit divisions and result queue,
//   QW = clog2 of the larger of MAX_WIDTH and MAX_HEIGHT (12 at defaults)
// the shared restoring divider takes one frame at a time behind a two-word queue;
//   full rises only when frames come faster than it drains them or results are not popped
// reset clears counters, queues and the divider sequencer and loads default gain and threshold
module threshold_blob_centroid
    import tbc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic [PIXEL_W-1:0]       blue,
    input  logic [PIXEL_W-1:0]       green,
    input  logic [PIXEL_W-1:0]       red,
    input  logic                     end_of_line,
    input  logic                     end_of_frame,
    input  logic                     push,
    output logic                     full,
    output logic [COORD_W-1:0]       centroid_x,
    output logic [COORD_W-1:0]       centroid_y,
    output logic [COUNT_W-1:0]       foreground_pixels,
    output logic                     centroid_valid,
    output logic                     empty,
    input  logic                     pop
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_HEIGHT);
    localparam int QW      = (CW > RW) ? CW : RW;
    localparam int SWM     = COUNT_W + QW;
    localparam int FRAME_W = COUNT_W + 2 * SWM;
    localparam int FQ_CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [GAIN_W-1:0]   gain_reg;
    logic [THR_W-1:0]    thr_reg;

    logic                pixel_valid;
    logic                pending_eof;
    logic                frame_push;
    logic [FRAME_W-1:0]  frame_wdata;
    logic [FRAME_W-1:0]  frame_rdata;
    logic                frame_pop;
    logic                frame_empty;
    logic [FQ_CNT_W-1:0] frame_count;
    logic [FQ_CNT_W:0]   frame_load;

    logic                res_push;
    logic [RES_W-1:0]    res_wdata;
    logic [RES_W-1:0]    res_rdata;
    logic                res_full;
    logic [FQ_CNT_W-1:0] res_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            thr_reg  <= THR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CONTRAST_GAIN:  gain_reg <= cfg_data[GAIN_W-1:0];
                REG_DARK_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
            endcase
        end
    end

    // an end-of-frame word still in the front pipe needs a queue slot too
    assign frame_load  = (FQ_CNT_W + 1)'(frame_count) + (FQ_CNT_W + 1)'(pending_eof);
    assign full        = (frame_load >= (FQ_CNT_W + 1)'(QUEUE_DEPTH));
    assign pixel_valid = push && !full;
    assign frame_empty = (frame_count == '0);

    tbc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .blue           (blue),
        .green          (green),
        .red            (red),
        .end_of_line    (end_of_line),
        .end_of_frame   (end_of_frame),
        .contrast_gain  (gain_reg),
        .dark_threshold (thr_reg),
        .pending_eof    (pending_eof),
        .frame_push     (frame_push),
        .frame_data     (frame_wdata)
    );

    tbc_fifo #(
        .WIDTH (FRAME_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_frame_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (frame_push),
        .wr_data (frame_wdata),
        .rd_en   (frame_pop),
        .rd_data (frame_rdata),
        .count   (frame_count)
    );

    tbc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_empty (frame_empty),
        .frame_data  (frame_rdata),
        .frame_pop   (frame_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res_data    (res_wdata)
    );

    tbc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wdata),
        .rd_en   (pop && !empty),
        .rd_data (res_rdata),
        .count   (res_count)
    );

    assign res_full = (res_count == FQ_CNT_W'(QUEUE_DEPTH));
    assign empty    = (res_count == '0);

    assign centroid_x        = res_rdata[RES_W-1 -: COORD_W];
    assign centroid_y        = res_rdata[RES_W-COORD_W-1 -: COORD_W];
    assign foreground_pixels = res_rdata[COUNT_W:1];
    assign centroid_valid    = res_rdata[0];

endmodule
